### src/msm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// msm_pkg: shared types, constants and arithmetic helpers
// Item structs, CORDIC arctangent table and saturation functions.
// ----------------------------------------------------------------------------
package msm_pkg;

    // CORDIC iteration count (8 .. 24)
    localparam int SINE_ITERATIONS = 16;
    localparam int ATAN_ENTRIES    = 24;
    localparam int CORDIC_STEPS    =
        (SINE_ITERATIONS < ATAN_ENTRIES) ? SINE_ITERATIONS : ATAN_ENTRIES;

    // Q2.30 datapath, with headroom for the rotation gain
    localparam int CORDIC_W = 34;

    localparam logic signed [CORDIC_W-1:0] CORDIC_X0    = 34'sd652032874;
    localparam logic signed [CORDIC_W-1:0] SINE_ROUND   = 34'sd16384;
    localparam logic        [15:0]         EIGHTH_TURN  = 16'h2000;
    localparam logic signed [17:0]         QUARTER_TURN = 18'sd16384;
    localparam logic signed [17:0]         HALF_TURN    = 18'sd32768;
    localparam logic signed [15:0]         SINE_MAX     = 16'sd32767;
    localparam logic signed [15:0]         SINE_MIN     = -16'sd32767;

    typedef logic signed [15:0] t_s16;

    typedef struct packed {
        t_s16        translation_speed;
        logic [15:0] heading_angle;
        t_s16        turn_speed;
    } t_in_item;

    typedef struct packed {
        t_s16 front_left_speed;
        t_s16 front_right_speed;
        t_s16 rear_left_speed;
        t_s16 rear_right_speed;
    } t_out_item;

    typedef struct packed {
        logic signed [CORDIC_W-1:0] x;
        logic signed [CORDIC_W-1:0] y;
        logic signed [CORDIC_W-1:0] z;
    } t_cordic_vec;

    typedef struct packed {
        t_cordic_vec vplus;
        t_cordic_vec vminus;
        t_s16        speed;
        t_s16        turn;
    } t_cordic_item;

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic signed [CORDIC_W-1:0] atan_turn(input int i);
        logic signed [CORDIC_W-1:0] v;
        unique case (i)
            0:       v = 34'sd536870912;
            1:       v = 34'sd316933406;
            2:       v = 34'sd167458907;
            3:       v = 34'sd85004756;
            4:       v = 34'sd42667331;
            5:       v = 34'sd21354465;
            6:       v = 34'sd10679838;
            7:       v = 34'sd5340245;
            8:       v = 34'sd2670163;
            9:       v = 34'sd1335087;
            10:      v = 34'sd667544;
            11:      v = 34'sd333772;
            12:      v = 34'sd166886;
            13:      v = 34'sd83443;
            14:      v = 34'sd41722;
            15:      v = 34'sd20861;
            16:      v = 34'sd10430;
            17:      v = 34'sd5215;
            18:      v = 34'sd2608;
            19:      v = 34'sd1304;
            20:      v = 34'sd652;
            21:      v = 34'sd326;
            22:      v = 34'sd163;
            23:      v = 34'sd81;
            default: v = '0;
        endcase
        return v;
    endfunction

    // fold the angle into [-quarter, +quarter] turn and build the start vector
    function automatic t_cordic_vec cordic_start(input logic [15:0] angle);
        logic signed [17:0] a;
        t_cordic_vec        v;
        a = 18'(signed'(angle));
        if (a > QUARTER_TURN) begin
            a = HALF_TURN - a;
        end else if (a < -QUARTER_TURN) begin
            a = -HALF_TURN - a;
        end
        v.x = CORDIC_X0;
        v.y = '0;
        v.z = CORDIC_W'({a, 16'h0000});
        return v;
    endfunction

    // one rotation step; i is constant at each call site
    function automatic t_cordic_vec cordic_step(input t_cordic_vec v, input int i);
        logic signed [CORDIC_W-1:0] dx;
        logic signed [CORDIC_W-1:0] dy;
        t_cordic_vec                r;
        dx = v.y >>> i;
        dy = v.x >>> i;
        if (!v.z[CORDIC_W-1]) begin
            r.x = v.x - dx;
            r.y = v.y + dy;
            r.z = v.z - atan_turn(i);
        end else begin
            r.x = v.x + dx;
            r.y = v.y - dy;
            r.z = v.z + atan_turn(i);
        end
        return r;
    endfunction

    // Q2.30 to Q1.15 with round half up, clamped symmetric
    function automatic t_s16 sine_q15(input logic signed [CORDIC_W-1:0] y);
        logic signed [CORDIC_W-1:0] sum;
        logic signed [CORDIC_W-16:0] s;
        t_s16                        r;
        sum = y + SINE_ROUND;
        s   = sum[CORDIC_W-1:15];
        if (s > CORDIC_W'(SINE_MAX)) begin
            r = SINE_MAX;
        end else if (s < CORDIC_W'(SINE_MIN)) begin
            r = SINE_MIN;
        end else begin
            r = s[15:0];
        end
        return r;
    endfunction

    function automatic t_s16 sat16(input logic signed [17:0] v);
        t_s16 r;
        if (v > 18'sd32767) begin
            r = 16'sh7fff;
        end else if (v < -18'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

### src/msm_fold.sv
`default_nettype none
// ----------------------------------------------------------------------------
// msm_fold: input stage
// Offsets the heading by an eighth turn both ways and folds each angle
// into the CORDIC start vector.
// ----------------------------------------------------------------------------
module msm_fold (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_valid,
    output logic                   o_stall,
    input  msm_pkg::t_in_item      i_item,
    output logic                   o_valid,
    input  wire                    i_stall,
    output msm_pkg::t_cordic_item  o_item
);
    import msm_pkg::*;

    logic         r_valid;
    t_cordic_item r_item;
    t_cordic_item n_item;
    logic         w_load;

    assign o_stall = r_valid && i_stall;
    assign w_load  = !o_stall;

    always_comb begin
        n_item.vplus  = cordic_start(i_item.heading_angle + EIGHTH_TURN);
        n_item.vminus = cordic_start(i_item.heading_angle - EIGHTH_TURN);
        n_item.speed  = i_item.translation_speed;
        n_item.turn   = i_item.turn_speed;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load && i_valid) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule
`default_nettype wire

### src/msm_cordic.sv
`default_nettype none
// ----------------------------------------------------------------------------
// msm_cordic: pipelined CORDIC rotator
// One register stage per iteration; both sine lanes advance together.
// ----------------------------------------------------------------------------
module msm_cordic (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_valid,
    output logic                   o_stall,
    input  msm_pkg::t_cordic_item  i_item,
    output logic                   o_valid,
    input  wire                    i_stall,
    output msm_pkg::t_cordic_item  o_item
);
    import msm_pkg::*;

    logic [CORDIC_STEPS-1:0] r_valid;
    logic [CORDIC_STEPS-1:0] w_stall;
    t_cordic_item            r_item [CORDIC_STEPS];
    t_cordic_item            n_item [CORDIC_STEPS];

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
        logic         w_in_valid;
        t_cordic_item w_in_item;

        if (k == 0) begin : g_first
            assign w_in_valid = i_valid;
            assign w_in_item  = i_item;
        end else begin : g_next
            assign w_in_valid = r_valid[k-1];
            assign w_in_item  = r_item[k-1];
        end

        // a stage holds only when full and blocked downstream
        if (k == CORDIC_STEPS - 1) begin : g_last
            assign w_stall[k] = r_valid[k] && i_stall;
        end else begin : g_mid
            assign w_stall[k] = r_valid[k] && w_stall[k+1];
        end

        always_comb begin
            n_item[k].vplus  = cordic_step(w_in_item.vplus, k);
            n_item[k].vminus = cordic_step(w_in_item.vminus, k);
            n_item[k].speed  = w_in_item.speed;
            n_item[k].turn   = w_in_item.turn;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (!w_stall[k]) begin
                r_valid[k] <= w_in_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!w_stall[k] && w_in_valid) begin
                r_item[k] <= n_item[k];
            end
        end
    end

    assign o_stall = w_stall[0];
    assign o_valid = r_valid[CORDIC_STEPS-1];
    assign o_item  = r_item[CORDIC_STEPS-1];

endmodule
`default_nettype wire

### src/msm_mix.sv
`default_nettype none
// ----------------------------------------------------------------------------
// msm_mix: sine rounding, speed scaling and wheel mixing
// Three stages: round/clamp sine, multiply and shift, add turn and saturate.
// ----------------------------------------------------------------------------
module msm_mix (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_valid,
    output logic                   o_stall,
    input  msm_pkg::t_cordic_item  i_item,
    output logic                   o_valid,
    input  wire                    i_stall,
    output msm_pkg::t_out_item     o_item
);
    import msm_pkg::*;

    // stage A: sines
    logic               r_va;
    t_s16               r_sin_plus;
    t_s16               r_sin_minus;
    t_s16               r_speed_a;
    t_s16               r_turn_a;
    // stage B: scaled products
    logic               r_vb;
    logic signed [16:0] r_p_plus;
    logic signed [16:0] r_p_minus;
    t_s16               r_turn_b;
    // stage C: result
    logic               r_vc;
    t_out_item          r_out;

    logic               w_stall_a;
    logic               w_stall_b;
    logic               w_stall_c;
    logic signed [31:0] w_prod_plus;
    logic signed [31:0] w_prod_minus;
    logic signed [17:0] w_p_plus;
    logic signed [17:0] w_p_minus;
    logic signed [17:0] w_turn;
    t_out_item          n_out;

    assign w_stall_c = r_vc && i_stall;
    assign w_stall_b = r_vb && w_stall_c;
    assign w_stall_a = r_va && w_stall_b;
    assign o_stall   = w_stall_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else begin
            if (!w_stall_a) r_va <= i_valid;
            if (!w_stall_b) r_vb <= r_va;
            if (!w_stall_c) r_vc <= r_vb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!w_stall_a && i_valid) begin
            r_sin_plus  <= sine_q15(i_item.vplus.y);
            r_sin_minus <= sine_q15(i_item.vminus.y);
            r_speed_a   <= i_item.speed;
            r_turn_a    <= i_item.turn;
        end
    end

    assign w_prod_plus  = r_speed_a * r_sin_plus;
    assign w_prod_minus = r_speed_a * r_sin_minus;

    // floor shift by 15 is the upper product bits
    always_ff @(posedge i_clk) begin
        if (!w_stall_b && r_va) begin
            r_p_plus  <= w_prod_plus[31:15];
            r_p_minus <= w_prod_minus[31:15];
            r_turn_b  <= r_turn_a;
        end
    end

    assign w_p_plus  = 18'(r_p_plus);
    assign w_p_minus = 18'(r_p_minus);
    assign w_turn    = 18'(r_turn_b);

    always_comb begin
        n_out.front_left_speed  = sat16(w_p_plus + w_turn);
        n_out.front_right_speed = sat16(w_p_minus - w_turn);
        n_out.rear_left_speed   = sat16(w_p_minus + w_turn);
        n_out.rear_right_speed  = sat16(w_p_plus - w_turn);
    end

    always_ff @(posedge i_clk) begin
        if (!w_stall_c && r_vb) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_vc;
    assign o_item  = r_out;

endmodule
`default_nettype wire

### src/mecanum_wheel_speed_mixer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mecanum_wheel_speed_mixer: mecanum inverse kinematics, four wheel setpoints
// Throughput: one command per cycle while the output is not stalled; every stage holds one item.
// Stalls fill bubbles; a stage holds only if it is full and blocked.
// Reset (sync, active low) clears all valid bits; no datapath state.
// ----------------------------------------------------------------------------
module mecanum_wheel_speed_mixer (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_stall,
    input  msm_pkg::t_in_item   i_item,
    output logic                o_valid,
    input  wire                 i_stall,
    output msm_pkg::t_out_item  o_item
);
    import msm_pkg::*;

    // input stage -> CORDIC
    logic         w_fold_valid;
    logic         w_fold_stall;
    t_cordic_item w_fold_item;
    // CORDIC -> mixer
    logic         w_cor_valid;
    logic         w_cor_stall;
    t_cordic_item w_cor_item;

    // Stage 0: heading +/- eighth turn, fold to +/- quarter turn
    msm_fold u_fold (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (i_item),
        .o_valid (w_fold_valid),
        .i_stall (w_fold_stall),
        .o_item  (w_fold_item)
    );

    // Stages 1..N: one CORDIC rotation per stage, plus and minus lanes
    msm_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_fold_valid),
        .o_stall (w_fold_stall),
        .i_item  (w_fold_item),
        .o_valid (w_cor_valid),
        .i_stall (w_cor_stall),
        .o_item  (w_cor_item)
    );

    // Last three stages: sine rounding, speed multiply, turn mix + saturate.
    // The final stage is the output register.
    msm_mix u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_cor_valid),
        .o_stall (w_cor_stall),
        .i_item  (w_cor_item),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (o_item)
    );

`ifndef SYNTH
    // input is only held off when the first stage is occupied
    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> w_fold_valid)
        else $error("input stalled with empty first stage");

    // an accepted command always lands in the first stage
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> w_fold_valid)
        else $error("accepted command lost at first stage");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && !o_stall && !w_cor_valid))
        else $error("pipeline not empty after reset");
`endif

endmodule
`default_nettype wire

### test/testbench.sv
// ----------------------------------------------------------------------------
// testbench: mecanum_wheel_speed_mixer wheel setpoint check
// Drives speed/heading/turn commands with random gaps and output stalls and
// compares each wheel setpoint against a CORDIC sine predictor kept here.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import msm_pkg::t_s16;
    import msm_pkg::t_in_item;
    import msm_pkg::t_out_item;

    // Rotation steps actually run: the arctangent table stops at 24 entries.
    localparam int ROT_STEPS =
        (msm_pkg::SINE_ITERATIONS < 24) ? msm_pkg::SINE_ITERATIONS : 24;
    localparam int LATENCY   = ROT_STEPS + 4;
    localparam int N_RANDOM  = 1200;

    // atan(2^-k) in 2^-32 turn units, rounded to nearest
    localparam longint ATAN_TURNS [24] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };

    typedef struct {
        t_in_item cmd;
        bit       drain;    // hold this item back until the mixer is empty
    } t_pending_cmd;

    logic      i_clk;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_stall;
    t_in_item  i_item  = '0;
    logic      o_valid;
    logic      i_stall = 1'b0;
    t_out_item o_item;

    t_pending_cmd cmd_queue[$];         // commands not yet offered
    t_out_item    setpoint_queue[$];    // predicted setpoints, oldest first
    int           mismatch_count = 0;

    bit cmd_fire  = 1'b0;   // command accepted at the last rising edge
    int send_gap  = 0;
    int hold_cnt  = 0;
    bit send_calm = 1'b0;   // stretch with no sender idling
    bit recv_calm = 1'b0;   // stretch with no receiver stalls

    mecanum_wheel_speed_mixer u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (o_item)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Q1.15 sine: fold into +-quarter turn, rotate in Q2.30, round and clamp
    // symmetric so that full scale maps to +-32767.
    function automatic t_s16 cordic_sine(input logic [15:0] angle);
        longint a;
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        a = $signed(angle);
        if (a > 16384) begin
            a = 32768 - a;
        end else if (a < -16384) begin
            a = -32768 - a;
        end
        x = 652032874;
        y = 0;
        z = a * 65536;
        for (int k = 0; k < ROT_STEPS; k++) begin
            dx = y >>> k;
            dy = x >>> k;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - ATAN_TURNS[k];
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + ATAN_TURNS[k];
            end
        end
        y = (y + 16384) >>> 15;
        if (y > 32767) y = 32767;
        if (y < -32767) y = -32767;
        return t_s16'(y);
    endfunction

    function automatic t_s16 clamp16(input longint v);
        if (v > 32767) return 16'sh7fff;
        if (v < -32768) return 16'sh8000;
        return t_s16'(v);
    endfunction

    // Wheels 1/4 ride on sin(angle + eighth turn), wheels 2/3 on
    // sin(angle - eighth turn); the turn speed adds on 1/3, subtracts on 2/4.
    function automatic t_out_item mix_wheels(input t_in_item c);
        logic [15:0] ang_lead;
        logic [15:0] ang_lag;
        longint      spd;
        longint      trn;
        longint      p_lead;
        longint      p_lag;
        t_out_item   r;
        ang_lead = c.heading_angle + 16'h2000;
        ang_lag  = c.heading_angle - 16'h2000;
        spd      = c.translation_speed;
        trn      = c.turn_speed;
        p_lead   = (spd * longint'(cordic_sine(ang_lead))) >>> 15;
        p_lag    = (spd * longint'(cordic_sine(ang_lag))) >>> 15;
        r.front_left_speed  = clamp16(p_lead + trn);
        r.front_right_speed = clamp16(p_lag - trn);
        r.rear_left_speed   = clamp16(p_lag + trn);
        r.rear_right_speed  = clamp16(p_lead - trn);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Mostly back to back, some short gaps, a few long ones.
    function automatic int draw_gap(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Signed field: mostly uniform, with extremes and small values mixed in.
    function automatic t_s16 draw_s16();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return t_s16'($urandom);
        if (r < 85) begin
            case ($urandom_range(0, 4))
                0:       return 16'sh7fff;
                1:       return 16'sh8000;
                2:       return 16'sh0001;
                3:       return 16'shffff;
                default: return 16'sh0000;
            endcase
        end
        return t_s16'($signed($urandom_range(0, 511)) - 256);
    endfunction

    task automatic queue_cmd(input t_s16 spd, input logic [15:0] ang,
                             input t_s16 trn, input bit drain);
        t_pending_cmd p;
        p.cmd.translation_speed = spd;
        p.cmd.heading_angle     = ang;
        p.cmd.turn_speed        = trn;
        p.drain                 = drain;
        cmd_queue.push_back(p);
    endtask

    task automatic compare_speed(input string name, input t_s16 want, input t_s16 got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: new command at the falling edge once the previous one went in
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!(i_valid && !cmd_fire)) begin
            if (send_gap != 0) begin
                i_valid  <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (cmd_queue.size() != 0 &&
                         !(cmd_queue[0].drain && setpoint_queue.size() != 0)) begin
                i_item   <= cmd_queue[0].cmd;
                i_valid  <= 1'b1;
                send_gap <= draw_gap(send_calm);
                cmd_queue.pop_front();
                if ($urandom_range(0, 49) == 0) send_calm <= !send_calm;
            end else begin
                // out of commands, or waiting for the mixer to drain
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver back-pressure, independent of o_valid.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_cnt != 0) begin
            i_stall  <= 1'b1;
            hold_cnt <= hold_cnt - 1;
        end else begin
            i_stall  <= 1'b0;
            hold_cnt <= draw_gap(recv_calm);
            if ($urandom_range(0, 63) == 0) recv_calm <= !recv_calm;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: both handshakes sampled at the rising edge
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            cmd_fire <= 1'b0;
        end else begin
            cmd_fire <= i_valid && !o_stall;
            if (i_valid && !o_stall) begin
                setpoint_queue.push_back(mix_wheels(i_item));
            end
            if (o_valid && !i_stall) begin
                if (setpoint_queue.size() == 0) begin
                    $error("setpoint item with no command outstanding");
                    mismatch_count++;
                end else begin
                    want = setpoint_queue.pop_front();
                    compare_speed("front_left_speed", want.front_left_speed,
                                  o_item.front_left_speed);
                    compare_speed("front_right_speed", want.front_right_speed,
                                  o_item.front_right_speed);
                    compare_speed("rear_left_speed", want.rear_left_speed,
                                  o_item.rear_left_speed);
                    compare_speed("rear_right_speed", want.rear_right_speed,
                                  o_item.rear_right_speed);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence: directed corners, random commands, drain, verdict
    // ------------------------------------------------------------------
    initial begin
        logic [15:0] ang;
        int          r;

        // Full-scale sine on the lead pair (heading an eighth turn) and on
        // the lag pair (heading minus an eighth turn -> -1.0).
        queue_cmd(16'sh7fff, 16'h2000, 16'sh0000, 1'b0);
        queue_cmd(16'sh8000, 16'h2000, 16'sh0000, 1'b0);
        queue_cmd(16'sh7fff, 16'he000, 16'sh0000, 1'b0);
        queue_cmd(16'sh8000, 16'ha000, 16'sh0000, 1'b0);
        // Saturating sums: high and low on both front wheels, high on rear right
        queue_cmd(16'sh7fff, 16'h2000, 16'sh7fff, 1'b0);
        queue_cmd(16'sh7fff, 16'h2000, 16'sh8000, 1'b0);
        queue_cmd(16'sh8000, 16'h2000, 16'sh8000, 1'b0);
        queue_cmd(16'sh8000, 16'h6000, 16'sh7fff, 1'b0);
        queue_cmd(16'sh7fff, 16'h6000, 16'sh8000, 1'b0);
        // Quadrant and fold boundaries of the heading
        queue_cmd(16'sh4000, 16'h0000, 16'sh0000, 1'b0);
        queue_cmd(16'sh4000, 16'h4000, 16'sh0001, 1'b0);
        queue_cmd(16'sh4000, 16'h8000, 16'shffff, 1'b0);
        queue_cmd(16'sh4000, 16'hc000, 16'sh0100, 1'b0);
        queue_cmd(16'sh7fff, 16'h6001, 16'sh0000, 1'b0);
        queue_cmd(16'sh7fff, 16'h5fff, 16'sh0000, 1'b0);
        queue_cmd(16'sh7fff, 16'h7fff, 16'sh0000, 1'b0);
        queue_cmd(16'sh7fff, 16'h8001, 16'sh0000, 1'b0);
        queue_cmd(16'sh7fff, 16'hffff, 16'sh0000, 1'b0);
        // Zero speed: turn only; and small odd values for the floor shift
        queue_cmd(16'sh0000, 16'h1234, 16'sh7fff, 1'b0);
        queue_cmd(16'shffff, 16'h3000, 16'sh0000, 1'b0);
        queue_cmd(16'sh0001, 16'h3000, 16'shffff, 1'b0);
        queue_cmd(16'sh8000, 16'hffff, 16'sh8000, 1'b0);

        for (int n = 0; n < N_RANDOM; n++) begin
            r = $urandom_range(0, 99);
            if (r < 75) begin
                ang = 16'($urandom);
            end else begin
                // near a multiple of an eighth turn, where folding and
                // full-scale clamping happen
                ang = 16'($urandom_range(0, 7) * 16'h2000 +
                          $urandom_range(0, 8) - 4);
            end
            // first random item and one mid-run wait for an empty pipeline
            queue_cmd(draw_s16(), ang, draw_s16(), n == 0 || n == N_RANDOM / 2);
        end

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (cmd_queue.size() != 0 || i_valid) @(posedge i_clk);
        while (setpoint_queue.size() != 0) @(posedge i_clk);
        // catch any stray item after the last expected one
        repeat (3 * LATENCY) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("[mecanum_wheel_speed_mixer] OK");
        end else begin
            $display("[mecanum_wheel_speed_mixer] ERROR");
        end
        $finish;
    end

    // Hang guard, far beyond the slowest legal run.
    initial begin
        #10_000_000;
        $display("[mecanum_wheel_speed_mixer] ERROR");
        $finish;
    end

endmodule
